FILE: design/ebhs_pkg.sv
package ebhs_pkg;

  // grid capacity
  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 256;

  // field widths
  localparam int CFG_W    = 9;
  localparam int INDEX_W  = 8;
  localparam int HEIGHT_W = 16;
  localparam int COORD_W  = 17;
  localparam int FRAC_W   = 16;
  localparam int WEIGHT_W = 16;
  localparam int OUT_W    = 24;
  localparam int OUT_FRAC = 8;

  // effective counts hold 2..MAX
  localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);

  // memory addressing: {row, col}
  localparam int COL_ADDR_W = $clog2(MAX_COLS);
  localparam int ROW_ADDR_W = $clog2(MAX_ROWS);
  localparam int MEM_ADDR_W = COL_ADDR_W + ROW_ADDR_W;
  localparam int MEM_DEPTH  = 1 << MEM_ADDR_W;

  // integer part of a scaled coordinate, up to twice the count
  localparam int X_W = COORD_W + COL_CNT_W - FRAC_W;
  localparam int Y_W = COORD_W + ROW_CNT_W - FRAC_W;

  // blend widths
  localparam int ROW_W   = HEIGHT_W + FRAC_W;
  localparam int SUM_W   = ROW_W + WEIGHT_W + 2;
  localparam int Q_SHIFT = 2 * FRAC_W - OUT_FRAC;

  // operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // register indexes
  localparam logic CFG_GRID_COLS = 1'b0;
  localparam logic CFG_GRID_ROWS = 1'b1;

  function automatic int unsigned clamp_count(logic [CFG_W-1:0] n, int unsigned maxv);
    int unsigned v;
    v = int'(n);
    if (v < 2) return 2;
    if (v > maxv) return maxv;
    return v;
  endfunction

endpackage

FILE: design/eased_bilinear_height_sampler.sv
// a height write leaves in_ready high: writes stream one per cycle unless a sample runs
// a sample runs from request to out_valid as scale, four reads from the single
// height memory port, a wait for the last read data, row blend, column blend
// no new request is taken until the result is loaded; an output stall delays that
// rst_n is synchronous, active low: control and grid counts (256 x 256) are reset,
// the height memory is not cleared and a cell holds nothing defined until written
module eased_bilinear_height_sampler (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [ebhs_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_operation,
  input  logic [ebhs_pkg::INDEX_W-1:0]        in_col_index,
  input  logic [ebhs_pkg::INDEX_W-1:0]        in_row_index,
  input  logic signed [ebhs_pkg::HEIGHT_W-1:0] in_height_value,
  input  logic [ebhs_pkg::COORD_W-1:0]        in_coord_u,
  input  logic [ebhs_pkg::COORD_W-1:0]        in_coord_v,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ebhs_pkg::OUT_W-1:0]   out_sampled_height
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_READ,
    S_WAIT,
    S_ROW,
    S_COL
  } state_t;

  state_t state_r, state_nxt;

  // effective grid counts, clamped when written
  logic [ebhs_pkg::COL_CNT_W-1:0] cols_eff_r;
  logic [ebhs_pkg::ROW_CNT_W-1:0] rows_eff_r;

  // request handshake
  logic in_accept;
  logic wr_in_grid;

  // sample datapath
  logic [ebhs_pkg::COORD_W-1:0]               u_r, v_r;
  logic [ebhs_pkg::COORD_W+ebhs_pkg::COL_CNT_W-1:0] su;
  logic [ebhs_pkg::COORD_W+ebhs_pkg::ROW_CNT_W-1:0] sv;
  logic [ebhs_pkg::X_W-1:0]                   x0_r, x1, rd_x;
  logic [ebhs_pkg::Y_W-1:0]                   y0_r, y1, rd_y;
  logic [ebhs_pkg::FRAC_W-1:0]                fx_r, fy_r, ease_frac;
  logic [ebhs_pkg::WEIGHT_W-1:0]              wx1_r, wy1_r, ease_weight;

  // read sequencer: four cells in order (x0,y0) (x1,y0) (x0,y1) (x1,y1)
  logic [1:0] rd_cnt_r;
  logic [1:0] rd_slot_r;
  logic       rd_pend_r;
  logic       rd_inb_r;
  logic       rd_inb;
  logic signed [ebhs_pkg::HEIGHT_W-1:0] h_r [4];

  // height memory, one port shared by writes and reads
  logic signed [ebhs_pkg::HEIGHT_W-1:0] height_mem [ebhs_pkg::MEM_DEPTH];
  logic signed [ebhs_pkg::HEIGHT_W-1:0] mem_q_r;
  logic                                 mem_we, mem_re;
  logic [ebhs_pkg::MEM_ADDR_W-1:0]      wr_addr, rd_addr;

  // blend
  logic signed [ebhs_pkg::HEIGHT_W:0]        dx_a, dx_b;
  logic signed [ebhs_pkg::ROW_W+1:0]         prod_a, prod_b, row_a, row_b;
  logic signed [ebhs_pkg::ROW_W-1:0]         ra_r, rb_r;
  logic signed [ebhs_pkg::ROW_W:0]           dr;
  logic signed [ebhs_pkg::SUM_W-1:0]         prod_c, sum_c;
  logic signed [ebhs_pkg::OUT_W-1:0]         out_data_r;
  logic                                      out_valid_r, out_valid_nxt;
  logic                                      out_load;

  // ---------------------------------------------------------------------------
  // configuration: counts are clamped to 2..MAX once at write time
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_eff_r <= ebhs_pkg::COL_CNT_W'(ebhs_pkg::clamp_count(
                      ebhs_pkg::CFG_W'(256), ebhs_pkg::MAX_COLS));
      rows_eff_r <= ebhs_pkg::ROW_CNT_W'(ebhs_pkg::clamp_count(
                      ebhs_pkg::CFG_W'(256), ebhs_pkg::MAX_ROWS));
    end else if (cfg_we) begin
      unique case (cfg_index)
        ebhs_pkg::CFG_GRID_COLS: begin
          cols_eff_r <= ebhs_pkg::COL_CNT_W'(ebhs_pkg::clamp_count(
                          cfg_wdata, ebhs_pkg::MAX_COLS));
        end
        ebhs_pkg::CFG_GRID_ROWS: begin
          rows_eff_r <= ebhs_pkg::ROW_CNT_W'(ebhs_pkg::clamp_count(
                          cfg_wdata, ebhs_pkg::MAX_ROWS));
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // request side: writes go straight to memory, samples start the sequencer
  // ---------------------------------------------------------------------------
  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;

  // writes outside the active grid are dropped
  assign wr_in_grid = (32'(in_col_index) < 32'(cols_eff_r))
                   && (32'(in_row_index) < 32'(rows_eff_r));
  assign mem_we  = in_accept && (in_operation == ebhs_pkg::OP_WRITE) && wr_in_grid;
  assign wr_addr = {ebhs_pkg::ROW_ADDR_W'(in_row_index), ebhs_pkg::COL_ADDR_W'(in_col_index)};

  // ---------------------------------------------------------------------------
  // scale: s = coord * (n - 1), integer cell and Q0.16 fraction
  // ---------------------------------------------------------------------------
  assign su = (ebhs_pkg::COORD_W+ebhs_pkg::COL_CNT_W)'(u_r)
            * (ebhs_pkg::COORD_W+ebhs_pkg::COL_CNT_W)'(cols_eff_r - ebhs_pkg::COL_CNT_W'(1));
  assign sv = (ebhs_pkg::COORD_W+ebhs_pkg::ROW_CNT_W)'(v_r)
            * (ebhs_pkg::COORD_W+ebhs_pkg::ROW_CNT_W)'(rows_eff_r - ebhs_pkg::ROW_CNT_W'(1));

  // high neighbor only moves when there is a fraction
  assign x1 = x0_r + ebhs_pkg::X_W'(fx_r != '0);
  assign y1 = y0_r + ebhs_pkg::Y_W'(fy_r != '0);

  // cell for the current read slot; cells off the grid read as zero
  assign rd_x    = rd_cnt_r[0] ? x1 : x0_r;
  assign rd_y    = rd_cnt_r[1] ? y1 : y0_r;
  assign rd_inb  = (32'(rd_x) < 32'(cols_eff_r)) && (32'(rd_y) < 32'(rows_eff_r));
  assign mem_re  = (state_r == S_READ) && rd_inb;
  assign rd_addr = {ebhs_pkg::ROW_ADDR_W'(rd_y), ebhs_pkg::COL_ADDR_W'(rd_x)};

  // ease unit shared between axes: x in the first read slot, y in the second
  assign ease_frac = rd_cnt_r[0] ? fy_r : fx_r;

  ebhs_ease u_ease (
    .frac   (ease_frac),
    .weight (ease_weight)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      height_mem[wr_addr] <= in_height_value;
    end
    if (mem_re) begin
      mem_q_r <= height_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // blend: r = h0*2^16 + (h1 - h0)*w1 per row, then the same across rows
  // ---------------------------------------------------------------------------
  assign dx_a   = (ebhs_pkg::HEIGHT_W+1)'(h_r[1]) - (ebhs_pkg::HEIGHT_W+1)'(h_r[0]);
  assign dx_b   = (ebhs_pkg::HEIGHT_W+1)'(h_r[3]) - (ebhs_pkg::HEIGHT_W+1)'(h_r[2]);
  assign prod_a = (ebhs_pkg::ROW_W+2)'(dx_a) * (ebhs_pkg::ROW_W+2)'($signed({1'b0, wx1_r}));
  assign prod_b = (ebhs_pkg::ROW_W+2)'(dx_b) * (ebhs_pkg::ROW_W+2)'($signed({1'b0, wx1_r}));
  assign row_a  = (ebhs_pkg::ROW_W+2)'($signed({h_r[0], {ebhs_pkg::FRAC_W{1'b0}}})) + prod_a;
  assign row_b  = (ebhs_pkg::ROW_W+2)'($signed({h_r[2], {ebhs_pkg::FRAC_W{1'b0}}})) + prod_b;

  assign dr     = (ebhs_pkg::ROW_W+1)'(rb_r) - (ebhs_pkg::ROW_W+1)'(ra_r);
  assign prod_c = ebhs_pkg::SUM_W'(dr) * ebhs_pkg::SUM_W'($signed({1'b0, wy1_r}));
  assign sum_c  = ebhs_pkg::SUM_W'($signed({ra_r, {ebhs_pkg::FRAC_W{1'b0}}})) + prod_c;

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      u_r <= in_coord_u;
      v_r <= in_coord_v;
    end
    if (state_r == S_SCALE) begin
      x0_r <= su[ebhs_pkg::FRAC_W +: ebhs_pkg::X_W];
      fx_r <= su[ebhs_pkg::FRAC_W-1:0];
      y0_r <= sv[ebhs_pkg::FRAC_W +: ebhs_pkg::Y_W];
      fy_r <= sv[ebhs_pkg::FRAC_W-1:0];
    end
    if (state_r == S_READ && rd_cnt_r == 2'd0) begin
      wx1_r <= ease_weight;
    end
    if (state_r == S_READ && rd_cnt_r == 2'd1) begin
      wy1_r <= ease_weight;
    end
    rd_slot_r <= rd_cnt_r;
    rd_inb_r  <= rd_inb;
    // read data lands in the cycle after its slot
    if (rd_pend_r) begin
      h_r[rd_slot_r] <= rd_inb_r ? mem_q_r : '0;
    end
    if (state_r == S_ROW) begin
      ra_r <= row_a[ebhs_pkg::ROW_W-1:0];
      rb_r <= row_b[ebhs_pkg::ROW_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer and output register
  // ---------------------------------------------------------------------------
  assign out_load = (state_r == S_COL) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && in_operation == ebhs_pkg::OP_SAMPLE) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: state_nxt = S_READ;
      S_READ: begin
        if (rd_cnt_r == 2'd3) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: state_nxt = S_ROW;
      S_ROW:  state_nxt = S_COL;
      S_COL: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_cnt_r    <= 2'd0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= (state_r == S_READ);
      if (state_r == S_READ) begin
        rd_cnt_r <= rd_cnt_r + 2'd1;
      end else begin
        rd_cnt_r <= 2'd0;
      end
      // floor to Q15.8 is the upper slice of the Q.32 sum
      if (out_load) begin
        out_data_r <= sum_c[ebhs_pkg::Q_SHIFT +: ebhs_pkg::OUT_W];
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sampled_height = out_data_r;

`ifndef SYNTHESIS
  // the last read of a sample is still landing while the sequencer waits
  a_wait_has_last_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT) |-> (rd_pend_r && rd_slot_r == 2'd3))
    else $error("last cell read not pending in wait state");

  // no read lands after the row blend has started
  a_row_after_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROW || state_r == S_COL) |-> !rd_pend_r)
    else $error("cell read landing during blend");

  // the single memory port never carries a write and a read together
  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("memory write and read in the same cycle");

  // a finished blend is loaded and the sequencer frees up
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished sample not presented");
`endif

endmodule

FILE: design/ebhs_ease.sv
module ebhs_ease (
  input  logic [ebhs_pkg::FRAC_W-1:0]   frac,
  output logic [ebhs_pkg::WEIGHT_W-1:0] weight
);

  logic [ebhs_pkg::FRAC_W-1:0]   op;
  logic [2*ebhs_pkg::FRAC_W-1:0] sq;
  logic [2*ebhs_pkg::FRAC_W-1:0] num;

  // upper half squares the distance to one
  assign op  = frac[ebhs_pkg::FRAC_W-1] ? (~frac + 1'b1) : frac;
  assign sq  = (2*ebhs_pkg::FRAC_W)'(op) * (2*ebhs_pkg::FRAC_W)'(op);
  assign num = frac[ebhs_pkg::FRAC_W-1]
             ? (((2*ebhs_pkg::FRAC_W)'(1) << (2*ebhs_pkg::FRAC_W-1)) - sq)
             : sq;
  // num stays below 2^31, weight is num >> 15
  assign weight = num[2*ebhs_pkg::FRAC_W-2 -: ebhs_pkg::WEIGHT_W];

endmodule

FILE: tb/eased_bilinear_height_sampler_tb.sv
`timescale 1ns / 100ps

module eased_bilinear_height_sampler_tb;

  // quiet cycles tolerated before the run is declared hung
  localparam int STALL_LIMIT  = 2000;
  // slack after the last owed height, to let anything still in flight settle
  localparam int DRAIN_CYCLES = 20;
  // long receiver hold-off used to back the block up
  localparam int HOLD_CYCLES  = 120;
  localparam int PHASE_ITEMS  = 106;

  typedef struct {
    logic                                 op;
    logic [ebhs_pkg::INDEX_W-1:0]         col;
    logic [ebhs_pkg::INDEX_W-1:0]         row;
    logic signed [ebhs_pkg::HEIGHT_W-1:0] height;
    logic [ebhs_pkg::COORD_W-1:0]         u;
    logic [ebhs_pkg::COORD_W-1:0]         v;
  } height_req_t;

  typedef struct {
    logic signed [ebhs_pkg::OUT_W-1:0] height;
    logic [ebhs_pkg::COORD_W-1:0]      u;
    logic [ebhs_pkg::COORD_W-1:0]      v;
  } height_exp_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 cfg_we = 1'b0;
  logic                                 cfg_index = ebhs_pkg::CFG_GRID_COLS;
  logic [ebhs_pkg::CFG_W-1:0]           cfg_wdata = '0;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic                                 in_operation = ebhs_pkg::OP_WRITE;
  logic [ebhs_pkg::INDEX_W-1:0]         in_col_index = '0;
  logic [ebhs_pkg::INDEX_W-1:0]         in_row_index = '0;
  logic signed [ebhs_pkg::HEIGHT_W-1:0] in_height_value = '0;
  logic [ebhs_pkg::COORD_W-1:0]         in_coord_u = '0;
  logic [ebhs_pkg::COORD_W-1:0]         in_coord_v = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic signed [ebhs_pkg::OUT_W-1:0]    out_sampled_height;

  eased_bilinear_height_sampler u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_col_index       (in_col_index),
    .in_row_index       (in_row_index),
    .in_height_value    (in_height_value),
    .in_coord_u         (in_coord_u),
    .in_coord_v         (in_coord_v),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sampled_height (out_sampled_height)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // requests waiting for the driver, and heights still owed by the block
  height_req_t pending_reqs[$];
  height_exp_t expected_heights[$];

  // shadow of the grid as the block should hold it, plus raw register values
  logic signed [ebhs_pkg::HEIGHT_W-1:0] shadow_heights [0:ebhs_pkg::MEM_DEPTH-1];
  logic [ebhs_pkg::CFG_W-1:0]           grid_cols_cfg = 9'd256;
  logic [ebhs_pkg::CFG_W-1:0]           grid_rows_cfg = 9'd256;

  // cells that some queued write will have filled, so a sample may read them
  bit filled_cells [0:ebhs_pkg::MEM_DEPTH-1];

  int  n_errors = 0;
  int  n_results = 0;
  int  n_queued = 0;
  int  quiet_cycles = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;

  // driver state
  height_req_t cur_req;
  bit          offering = 1'b0;
  int          tx_gap = 0;

  // monitor state
  height_exp_t head_exp;
  int          rx_wait = 0;
  int          hold_left = 0;

  initial begin
    for (int i = 0; i < ebhs_pkg::MEM_DEPTH; i++) begin
      shadow_heights[ebhs_pkg::MEM_ADDR_W'(i)] = '0;
      filled_cells[ebhs_pkg::MEM_ADDR_W'(i)] = 1'b0;
    end
  end

  // row-major cell address, only used for cells inside the grid
  function automatic logic [ebhs_pkg::MEM_ADDR_W-1:0] cell_addr(input int unsigned c,
                                                                input int unsigned r);
    return ebhs_pkg::MEM_ADDR_W'(r * ebhs_pkg::MAX_COLS + c);
  endfunction

  // register value as the block uses it: below 2 acts as 2, above capacity saturates
  function automatic int unsigned eff_count(input logic [ebhs_pkg::CFG_W-1:0] raw,
                                            input int unsigned cap);
    if (raw < 2) return 2;
    if (raw > cap) return cap;
    return int'(raw);
  endfunction

  // scale a Q1.16 coordinate by count-1; low cell, high cell and fraction
  function automatic void split_coord(input logic [ebhs_pkg::COORD_W-1:0] c,
                                      input int unsigned n,
                                      output int unsigned lo, output int unsigned hi,
                                      output int unsigned frac);
    int unsigned scaled;
    scaled = c * (n - 1);
    lo     = scaled >> ebhs_pkg::FRAC_W;
    frac   = scaled & 32'h0000_FFFF;
    hi     = lo + ((frac != 0) ? 1 : 0);
  endfunction

  // smoothstep-like ease weight, Q0.16 truncated, 0..65535
  function automatic longint ease_q16(input int unsigned f);
    longint g;
    if (f < 32768) return (longint'(f) * longint'(f)) >> 15;
    g = 65536 - longint'(f);
    return ((longint'(1) << 31) - g * g) >> 15;
  endfunction

  // cells past the active grid read as zero
  function automatic longint grid_cell(input int unsigned c, input int unsigned r,
                                       input int unsigned cols, input int unsigned rows);
    if (c >= cols || r >= rows) return 0;
    return longint'(shadow_heights[cell_addr(c, r)]);
  endfunction

  // eased bilinear blend of the four neighbors, Q.32 sum floored to Q15.8
  function automatic logic signed [ebhs_pkg::OUT_W-1:0] blend_height(
      input logic [ebhs_pkg::COORD_W-1:0] u, input logic [ebhs_pkg::COORD_W-1:0] v);
    int unsigned cols, rows, x0, x1, fx, y0, y1, fy;
    longint wx0, wx1, wy0, wy1, acc;
    cols = eff_count(grid_cols_cfg, ebhs_pkg::MAX_COLS);
    rows = eff_count(grid_rows_cfg, ebhs_pkg::MAX_ROWS);
    split_coord(u, cols, x0, x1, fx);
    split_coord(v, rows, y0, y1, fy);
    wx1 = ease_q16(fx);
    wx0 = 65536 - wx1;
    wy1 = ease_q16(fy);
    wy0 = 65536 - wy1;
    acc = grid_cell(x0, y0, cols, rows) * wx0 * wy0
        + grid_cell(x1, y0, cols, rows) * wx1 * wy0
        + grid_cell(x0, y1, cols, rows) * wx0 * wy1
        + grid_cell(x1, y1, cols, rows) * wx1 * wy1;
    acc = acc >>> ebhs_pkg::Q_SHIFT;
    return acc[ebhs_pkg::OUT_W-1:0];
  endfunction

  // effect of one accepted request on the shadow grid and the owed results
  function automatic void absorb_request(input height_req_t req);
    height_exp_t e;
    if (req.op == ebhs_pkg::OP_WRITE) begin
      if (req.col < eff_count(grid_cols_cfg, ebhs_pkg::MAX_COLS) &&
          req.row < eff_count(grid_rows_cfg, ebhs_pkg::MAX_ROWS))
        shadow_heights[cell_addr(req.col, req.row)] = req.height;
    end else begin
      e.height = blend_height(req.u, req.v);
      e.u = req.u;
      e.v = req.v;
      expected_heights.push_back(e);
    end
  endfunction

  // heights lean toward the two extremes
  function automatic logic signed [ebhs_pkg::HEIGHT_W-1:0] rand_height();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // coordinate mix: edges, beyond the grid, coarse lattice, plain interior
  function automatic logic [ebhs_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 17'd65536;
      2:       return 17'($urandom_range(65537, 131071));
      3:       return 17'($urandom_range(0, 131071));
      4:       return 17'($urandom_range(0, 16) * 4096);
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic queue_write(input int unsigned c, input int unsigned r,
                             input logic signed [ebhs_pkg::HEIGHT_W-1:0] h);
    height_req_t req;
    req.op     = ebhs_pkg::OP_WRITE;
    req.col    = c[ebhs_pkg::INDEX_W-1:0];
    req.row    = r[ebhs_pkg::INDEX_W-1:0];
    req.height = h;
    req.u      = 17'($urandom);
    req.v      = 17'($urandom);
    if (c < eff_count(grid_cols_cfg, ebhs_pkg::MAX_COLS) &&
        r < eff_count(grid_rows_cfg, ebhs_pkg::MAX_ROWS))
      filled_cells[cell_addr(c, r)] = 1'b1;
    pending_reqs.push_back(req);
    n_queued++;
  endtask

  // a sample may only touch cells already written, so fill gaps first
  task automatic fill_cell(input int unsigned c, input int unsigned r);
    if (c < eff_count(grid_cols_cfg, ebhs_pkg::MAX_COLS) &&
        r < eff_count(grid_rows_cfg, ebhs_pkg::MAX_ROWS)) begin
      if (!filled_cells[cell_addr(c, r)])
        queue_write(c, r, rand_height());
    end
  endtask

  task automatic queue_sample(input logic [ebhs_pkg::COORD_W-1:0] u,
                              input logic [ebhs_pkg::COORD_W-1:0] v);
    int unsigned x0, x1, fx, y0, y1, fy;
    height_req_t req;
    split_coord(u, eff_count(grid_cols_cfg, ebhs_pkg::MAX_COLS), x0, x1, fx);
    split_coord(v, eff_count(grid_rows_cfg, ebhs_pkg::MAX_ROWS), y0, y1, fy);
    fill_cell(x0, y0);
    fill_cell(x1, y0);
    fill_cell(x0, y1);
    fill_cell(x1, y1);
    req.op     = ebhs_pkg::OP_SAMPLE;
    req.col    = 8'($urandom);
    req.row    = 8'($urandom);
    req.height = 16'($urandom);
    req.u      = u;
    req.v      = v;
    pending_reqs.push_back(req);
    n_queued++;
  endtask

  // register writes, only issued while the block is idle
  task automatic set_grid(input logic [ebhs_pkg::CFG_W-1:0] cols_raw,
                          input logic [ebhs_pkg::CFG_W-1:0] rows_raw);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= ebhs_pkg::CFG_GRID_COLS;
    cfg_wdata <= cols_raw;
    @(posedge clk);
    cfg_index <= ebhs_pkg::CFG_GRID_ROWS;
    cfg_wdata <= rows_raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    grid_cols_cfg = cols_raw;
    grid_rows_cfg = rows_raw;
  endtask

  // nothing queued, nothing offered, nothing owed, then let trailing writes land
  task automatic wait_idle();
    while (offering || pending_reqs.size() != 0 || expected_heights.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed samples, some in-grid writes, some stray writes;
  // every queued request counts, gap fills included
  task automatic random_phase(input int n_items);
    int start;
    int pick;
    int unsigned c, r;
    start = n_queued;
    while (n_queued - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        queue_sample(rand_coord(), rand_coord());
      end else if (pick < 85) begin
        queue_write($urandom_range(0, eff_count(grid_cols_cfg, ebhs_pkg::MAX_COLS) - 1),
                    $urandom_range(0, eff_count(grid_rows_cfg, ebhs_pkg::MAX_ROWS) - 1),
                    rand_height());
      end else begin
        // stray write, possibly past the grid and then dropped by the block
        c = $urandom_range(0, 255);
        r = $urandom_range(0, 255);
        queue_write(c, r, rand_height());
      end
    end
  endtask

  // driver: presents one request at a time, holds it until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_request(cur_req);
        offering = 1'b0;
        tx_gap = tx_idle_on ? $urandom_range(0, 3) : 0;
      end
      if (!offering) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          offering = 1'b1;
          in_operation    <= cur_req.op;
          in_col_index    <= cur_req.col;
          in_row_index    <= cur_req.row;
          in_height_value <= cur_req.height;
          in_coord_u      <= cur_req.u;
          in_coord_v      <= cur_req.v;
        end
      end
      in_valid <= offering;
    end
  end

  // monitor: checks each result against the oldest owed height
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_heights.size() == 0) begin
          $display("%0t: sampled_height expected none actual %0d", $time, out_sampled_height);
          n_errors++;
        end else begin
          head_exp = expected_heights.pop_front();
          if (out_sampled_height !== head_exp.height) begin
            $display("%0t: sampled_height u=%0d v=%0d expected %0d actual %0d", $time,
                     head_exp.u, head_exp.v, head_exp.height, out_sampled_height);
            n_errors++;
          end
        end
        n_results++;
        // back-pressure bursts so the block fills up and stops taking requests
        if (n_results == 30 || n_results == 500) hold_left = HOLD_CYCLES;
        rx_wait = rx_idle_on ? $urandom_range(0, 3) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake on any port
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int ph;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: raw counts below 2 give a 2 x 2 grid
    set_grid(9'd0, 9'd1);
    queue_write(0, 0, 16'sh7FFF);
    queue_write(1, 0, 16'sh8000);
    queue_write(0, 1, 16'sh8000);
    queue_write(1, 1, 16'sh7FFF);
    // writes past the grid are dropped
    queue_write(2, 0, 16'sd100);
    queue_write(255, 255, -16'sd1);
    // corners, exact half, either side of the half, far edge, beyond the edge
    queue_sample(17'd0, 17'd0);
    queue_sample(17'd65536, 17'd65536);
    queue_sample(17'd32768, 17'd32768);
    queue_sample(17'd32767, 17'd32767);
    queue_sample(17'd1, 17'd65535);
    queue_sample(17'd65535, 17'd1);
    queue_sample(17'd131071, 17'd131071);
    queue_sample(17'd65536, 17'd0);
    queue_sample(17'd0, 17'd65536);
    queue_sample(17'd98304, 17'd16384);
    queue_sample(17'd131071, 17'd0);
    queue_sample(17'd40000, 17'd24000);
    wait_idle();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       set_grid(9'd256, 9'd256);
        1:       set_grid(9'd2, 9'd2);
        2:       set_grid(9'd17, 9'd5);
        3:       set_grid(9'd511, 9'd257);   // both saturate at capacity
        4:       set_grid(9'd3, 9'd130);
        5:       set_grid(9'd200, 9'd33);
        6:       set_grid(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
        default: set_grid(9'd1, 9'd256);
      endcase
      // some phases run with no idling on one or both sides
      tx_idle_on = (ph % 3 != 2);
      rx_idle_on = (ph % 4 != 1);
      random_phase(PHASE_ITEMS);
      wait_idle();
    end

    if (n_errors == 0 && expected_heights.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
design/ebhs_pkg.sv
design/ebhs_ease.sv
design/eased_bilinear_height_sampler.sv
tb/eased_bilinear_height_sampler_tb.sv
